// ===== rtl/dmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared types and constants for the DNS message parser.
// ----------------------------------------------------------------------------
package dmp_pkg;

  localparam logic [7:0] PTR_MIN  = 8'd192;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic [3:0] HDR_IDENT_BYTE = 4'd1;
  localparam logic [3:0] HDR_CNT_FIRST  = 4'd5;
  localparam logic [3:0] HDR_LAST_BYTE  = 4'd11;
  localparam logic [3:0] FIX_TYPE_BYTE  = 4'd1;
  localparam logic [3:0] FIX_CLASS_BYTE = 4'd3;
  localparam logic [3:0] FIX_TTL_BYTE   = 4'd7;
  localparam logic [3:0] FIX_LAST_BYTE  = 4'd9;

  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_CHAR   = 3'd1;
  localparam logic [2:0] KIND_RECORD = 3'd2;
  localparam logic [2:0] KIND_DATA   = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  localparam logic [1:0] VERD_NONE  = 2'd0;
  localparam logic [1:0] VERD_OK    = 2'd1;
  localparam logic [1:0] VERD_TRUNC = 2'd2;
  localparam logic [1:0] VERD_TRAIL = 2'd3;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_NAME   = 6'b000010,
    PH_PTR    = 6'b000100,
    PH_FIXED  = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  verdict;
    logic [7:0]  byte_value;
    logic [15:0] txn_id;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [31:0] ttl;
    logic [15:0] data_len;
  } result_t;

endpackage

// ===== rtl/dmp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_core
// Byte-wise parse state and the result for the beat being taken.
// ----------------------------------------------------------------------------
module dmp_core import dmp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] byte_in,
  input  logic       last_byte,
  output logic       hit,
  output result_t    res
);

  typedef struct packed {
    logic       found;
    logic [1:0] idx;
  } sect_pick_t;

  phase_t           phase, phase_next;
  logic [3:0]       field_byte_count, field_byte_count_next;
  logic [7:0]       label_remaining, label_remaining_next;
  logic [1:0]       section_index, section_index_next;
  logic [15:0]      records_left, records_left_next;
  logic [3:0][15:0] section_counts, section_counts_next;
  logic [15:0]      ident_reg, ident_reg_next;
  logic [31:0]      field_shift, field_shift_next;
  logic [15:0]      type_reg, type_reg_next;
  logic [15:0]      class_reg, class_reg_next;
  logic [31:0]      ttl_reg, ttl_reg_next;
  logic [15:0]      data_remaining, data_remaining_next;

  logic [31:0] shift_in;
  logic [3:0]  cnt_inc;
  logic [3:0]  cnt_off;
  logic [15:0] rl_dec;
  logic [15:0] dr_dec;
  logic        finish_rec;
  logic        start_sec;
  logic [2:0]  start_from;
  logic        trailing;
  sect_pick_t  pick;

  // lowest section at or above 'from' with a nonzero count
  function automatic sect_pick_t section_pick(input logic [3:0][15:0] counts,
                                              input logic [2:0] from);
    sect_pick_t p;
    p = '0;
    for (int s = 3; s >= 0; s--) begin
      if (3'(s) >= from && counts[s] != 16'd0) begin
        p.found = 1'b1;
        p.idx   = 2'(s);
      end
    end
    return p;
  endfunction

  assign shift_in = {field_shift[23:0], byte_in};
  assign cnt_inc  = field_byte_count + 4'd1;
  assign cnt_off  = field_byte_count - HDR_CNT_FIRST;
  assign rl_dec   = records_left - 16'd1;
  assign dr_dec   = data_remaining - 16'd1;

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    label_remaining_next  = label_remaining;
    section_index_next    = section_index;
    records_left_next     = records_left;
    section_counts_next   = section_counts;
    ident_reg_next        = ident_reg;
    field_shift_next      = field_shift;
    type_reg_next         = type_reg;
    class_reg_next        = class_reg;
    ttl_reg_next          = ttl_reg;
    data_remaining_next   = data_remaining;
    res        = '0;
    hit        = 1'b0;
    finish_rec = 1'b0;
    start_sec  = 1'b0;
    start_from = 3'd0;
    trailing   = 1'b0;
    pick       = '0;

    unique case (phase)
      PH_HEADER: begin
        field_shift_next      = shift_in;
        field_byte_count_next = cnt_inc;
        if (field_byte_count == HDR_IDENT_BYTE) ident_reg_next = shift_in[15:0];
        if (field_byte_count >= HDR_CNT_FIRST && field_byte_count[0])
          section_counts_next[cnt_off[2:1]] = shift_in[15:0];
        if (field_byte_count >= HDR_LAST_BYTE) begin
          hit                    = 1'b1;
          res.kind               = KIND_HEADER;
          res.txn_id             = ident_reg_next;
          res.question_count     = section_counts_next[0];
          res.answer_count       = section_counts_next[1];
          res.authority_count    = section_counts_next[2];
          res.additional_count   = section_counts_next[3];
          field_byte_count_next  = 4'd0;
          field_shift_next       = 32'd0;
          start_sec              = 1'b1;
          start_from             = 3'd0;
        end
      end
      PH_NAME: begin
        if (label_remaining != 8'd0) begin
          hit                  = 1'b1;
          res.kind             = KIND_CHAR;
          res.byte_value       = byte_in;
          label_remaining_next = label_remaining - 8'd1;
        end else if (byte_in == 8'd0) begin
          phase_next            = PH_FIXED;
          field_byte_count_next = 4'd0;
          field_shift_next      = 32'd0;
        end else if (byte_in >= PTR_MIN) begin
          phase_next = PH_PTR;
        end else begin
          // inner length byte shows as a dot
          if (field_byte_count != 4'd0) begin
            hit            = 1'b1;
            res.kind       = KIND_CHAR;
            res.byte_value = DOT_CHAR;
          end
          label_remaining_next  = byte_in;
          field_byte_count_next = 4'd1;
        end
      end
      PH_PTR: begin
        phase_next            = PH_FIXED;
        field_byte_count_next = 4'd0;
        field_shift_next      = 32'd0;
      end
      PH_FIXED: begin
        field_shift_next      = shift_in;
        field_byte_count_next = cnt_inc;
        if (field_byte_count == FIX_TYPE_BYTE) type_reg_next = shift_in[15:0];
        if (field_byte_count == FIX_CLASS_BYTE) begin
          class_reg_next = shift_in[15:0];
          if (section_index == 2'd0) begin
            hit          = 1'b1;
            res.kind     = KIND_RECORD;
            res.rtype    = type_reg;
            res.rclass   = shift_in[15:0];
            ttl_reg_next = 32'd0;
            finish_rec   = 1'b1;
          end
        end
        if (field_byte_count == FIX_TTL_BYTE) ttl_reg_next = shift_in;
        if (field_byte_count >= FIX_LAST_BYTE) begin
          data_remaining_next = shift_in[15:0];
          hit          = 1'b1;
          res.kind     = KIND_RECORD;
          res.rtype    = type_reg;
          res.rclass   = class_reg;
          res.ttl      = ttl_reg;
          res.data_len = shift_in[15:0];
          if (shift_in[15:0] == 16'd0) finish_rec = 1'b1;
          else phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        hit                 = 1'b1;
        res.kind            = KIND_DATA;
        res.byte_value      = byte_in;
        data_remaining_next = dr_dec;
        if (dr_dec == 16'd0) finish_rec = 1'b1;
      end
      default: begin
        trailing = 1'b1;
      end
    endcase

    if (finish_rec) begin
      records_left_next = rl_dec;
      if (rl_dec == 16'd0) begin
        start_sec  = 1'b1;
        start_from = {1'b0, section_index} + 3'd1;
      end else begin
        phase_next            = PH_NAME;
        field_byte_count_next = 4'd0;
        label_remaining_next  = 8'd0;
      end
    end

    if (start_sec) begin
      pick = section_pick(section_counts_next, start_from);
      if (pick.found) begin
        section_index_next    = pick.idx;
        records_left_next     = section_counts_next[pick.idx];
        phase_next            = PH_NAME;
        field_byte_count_next = 4'd0;
        label_remaining_next  = 8'd0;
      end else begin
        phase_next = PH_DONE;
      end
    end

    if (last_byte) begin
      if (!hit) res.kind = KIND_END;
      hit = 1'b1;
      if (trailing)                res.verdict = VERD_TRAIL;
      else if (phase_next == PH_DONE) res.verdict = VERD_OK;
      else                         res.verdict = VERD_TRUNC;
    end
  end

  // end mark puts everything back for the next datagram
  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase            <= PH_HEADER;
      field_byte_count <= '0;
      label_remaining  <= '0;
      section_index    <= '0;
      records_left     <= '0;
      section_counts   <= '0;
      ident_reg        <= '0;
      field_shift      <= '0;
      type_reg         <= '0;
      class_reg        <= '0;
      ttl_reg          <= '0;
      data_remaining   <= '0;
    end else if (take) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      label_remaining  <= label_remaining_next;
      section_index    <= section_index_next;
      records_left     <= records_left_next;
      section_counts   <= section_counts_next;
      ident_reg        <= ident_reg_next;
      field_shift      <= field_shift_next;
      type_reg         <= type_reg_next;
      class_reg        <= class_reg_next;
      ttl_reg          <= ttl_reg_next;
      data_remaining   <= data_remaining_next;
    end
  end

endmodule

// ===== rtl/dmp_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_out_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module dmp_out_buf import dmp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  input  logic    result_stall,
  output logic    result_valid,
  output result_t dout,
  output logic    full
);

  logic    skid_valid;
  result_t skid_data;
  logic    advance;

  // output register free for a new beat this cycle
  assign advance = !result_valid || !result_stall;
  assign full    = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (advance) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= load;
      end
    end else if (load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dout <= skid_valid ? skid_data : din;
    end else if (load) begin
      skid_data <= din;
    end
  end

endmodule

// ===== rtl/dns_message_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_message_parser
// Streams a DNS datagram byte by byte and reports header, name characters,
// record fields, data bytes and an end verdict.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+------------------------------------
//  byte    | byte_valid / byte_stall     | byte_in, last_byte
//  result  | result_valid / result_stall | kind, verdict, byte_value, header,
//          |                             | record fields
//
//  One byte per clock while byte_stall is low; each byte is decoded in the
//  cycle it is taken and its result is registered for the result channel.
//  A second result is held in a skid entry while the output is stalled;
//  byte_stall is high only while that entry is occupied.
//  rst is synchronous and clears parse state and both result slots; the
//  end-mark byte also returns parse state to its reset values.
// ----------------------------------------------------------------------------
module dns_message_parser import dmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_in,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  kind,
  output logic [1:0]  verdict,
  output logic [7:0]  byte_value,
  output logic [15:0] txn_id,
  output logic [15:0] question_count,
  output logic [15:0] answer_count,
  output logic [15:0] authority_count,
  output logic [15:0] additional_count,
  output logic [15:0] rtype,
  output logic [15:0] rclass,
  output logic [31:0] ttl,
  output logic [15:0] data_len
);

  logic    take;
  logic    hit;
  result_t res;
  result_t res_q;

  assign take = byte_valid && !byte_stall;

  dmp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .byte_in   (byte_in),
    .last_byte (last_byte),
    .hit       (hit),
    .res       (res)
  );

  dmp_out_buf u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (take && hit),
    .din          (res),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .dout         (res_q),
    .full         (byte_stall)
  );

  assign kind             = res_q.kind;
  assign verdict          = res_q.verdict;
  assign byte_value       = res_q.byte_value;
  assign txn_id           = res_q.txn_id;
  assign question_count   = res_q.question_count;
  assign answer_count     = res_q.answer_count;
  assign authority_count  = res_q.authority_count;
  assign additional_count = res_q.additional_count;
  assign rtype            = res_q.rtype;
  assign rclass           = res_q.rclass;
  assign ttl              = res_q.ttl;
  assign data_len         = res_q.data_len;

endmodule

// ===== rtl/dmp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_port_checks
// Port-level checks for the DNS message parser, bound to the top level.
// ----------------------------------------------------------------------------
module dmp_port_checks import dmp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic        last_byte,
  input logic        result_valid,
  input logic        result_stall,
  input logic [2:0]  kind,
  input logic [1:0]  verdict
);

  // a stalled result beat stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  // an end-mark byte always yields a result beat
  a_end_result: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && last_byte |=> result_valid)
    else $error("end-mark byte gave no result");

  // input only backs up once the output register is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid)
    else $error("byte_stall with empty output");

  // an end-only beat carries a verdict
  a_end_verdict: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_END |-> verdict != VERD_NONE)
    else $error("end-only beat without verdict");

endmodule

bind dns_message_parser dmp_port_checks u_dmp_checker (.*);

// ===== bench/dmp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmp_checker
// Watches both channels of the DNS message parser. It decodes every accepted
// byte with its own copy of the parse state, queues the result that byte
// should give and compares each accepted result with the oldest one queued.
// ----------------------------------------------------------------------------
module dmp_checker import dmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  byte_in,
  input  logic        last_byte,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [2:0]  kind,
  input  logic [1:0]  verdict,
  input  logic [7:0]  byte_value,
  input  logic [15:0] txn_id,
  input  logic [15:0] question_count,
  input  logic [15:0] answer_count,
  input  logic [15:0] authority_count,
  input  logic [15:0] additional_count,
  input  logic [15:0] rtype,
  input  logic [15:0] rclass,
  input  logic [31:0] ttl,
  input  logic [15:0] data_len,
  output int          fail_count,
  output int          outstanding,
  output int          checked_count
);

  // parse state of the predictor
  phase_t      ph;
  logic [3:0]  step;
  logic [7:0]  lab_left;
  logic [1:0]  sect;
  logic [15:0] recs_left;
  logic [15:0] sec_cnt [4];
  logic [15:0] ident;
  logic [31:0] acc;
  logic [15:0] typ;
  logic [15:0] cls;
  logic [31:0] ttl_r;
  logic [15:0] dleft;

  result_t due_results [$];
  result_t want;
  bit      produced;
  int      n_fail;
  int      n_checked;

  function automatic void clear_parse();
    ph        = PH_HEADER;
    step      = '0;
    lab_left  = '0;
    sect      = '0;
    recs_left = '0;
    for (int s = 0; s < 4; s++) sec_cnt[s] = '0;
    ident     = '0;
    acc       = '0;
    typ       = '0;
    cls       = '0;
    ttl_r     = '0;
    dleft     = '0;
  endfunction

  // first section from 'from' onwards that holds records, or done
  function automatic void open_section(int from);
    bit found;
    found = 1'b0;
    for (int s = from; s < 4; s++) begin
      if (!found && sec_cnt[s] != 0) begin
        found     = 1'b1;
        sect      = s[1:0];
        recs_left = sec_cnt[s];
        ph        = PH_NAME;
        step      = '0;
        lab_left  = '0;
      end
    end
    if (!found) ph = PH_DONE;
  endfunction

  function automatic void close_record();
    recs_left = recs_left - 16'd1;
    if (recs_left == 0) begin
      open_section(int'(sect) + 1);
    end else begin
      ph       = PH_NAME;
      step     = '0;
      lab_left = '0;
    end
  endfunction

  function automatic void close_name();
    ph   = PH_FIXED;
    step = '0;
    acc  = '0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic fin,
                                     output bit has, output result_t r);
    logic [3:0] c;
    bit         trail;
    r     = '0;
    has   = 1'b0;
    trail = 1'b0;
    c     = step;
    case (ph)
      PH_HEADER: begin
        acc = {acc[23:0], b};
        if (c == HDR_IDENT_BYTE) ident = acc[15:0];
        if (c >= HDR_CNT_FIRST && c <= HDR_LAST_BYTE && c[0])
          sec_cnt[2'((c - HDR_CNT_FIRST) >> 1)] = acc[15:0];
        step = c + 4'd1;
        if (c >= HDR_LAST_BYTE) begin
          has                = 1'b1;
          r.kind             = KIND_HEADER;
          r.txn_id           = ident;
          r.question_count   = sec_cnt[0];
          r.answer_count     = sec_cnt[1];
          r.authority_count  = sec_cnt[2];
          r.additional_count = sec_cnt[3];
          step               = '0;
          acc                = '0;
          open_section(0);
        end
      end
      PH_NAME: begin
        if (lab_left != 0) begin
          has          = 1'b1;
          r.kind       = KIND_CHAR;
          r.byte_value = b;
          lab_left     = lab_left - 8'd1;
        end else if (b == 8'd0) begin
          close_name();
        end else if (b >= PTR_MIN) begin
          ph = PH_PTR;
        end else begin
          // separator dot for every label but the first
          if (step != 0) begin
            has          = 1'b1;
            r.kind       = KIND_CHAR;
            r.byte_value = DOT_CHAR;
          end
          lab_left = b;
          step     = 4'd1;
        end
      end
      PH_PTR: close_name();
      PH_FIXED: begin
        acc  = {acc[23:0], b};
        step = c + 4'd1;
        if (c == FIX_TYPE_BYTE) typ = acc[15:0];
        if (c == FIX_CLASS_BYTE) begin
          cls = acc[15:0];
          if (sect == 0) begin
            has      = 1'b1;
            r.kind   = KIND_RECORD;
            r.rtype  = typ;
            r.rclass = cls;
            ttl_r    = '0;
            close_record();
          end
        end
        if (c == FIX_TTL_BYTE) ttl_r = acc;
        if (c >= FIX_LAST_BYTE) begin
          dleft      = acc[15:0];
          has        = 1'b1;
          r.kind     = KIND_RECORD;
          r.rtype    = typ;
          r.rclass   = cls;
          r.ttl      = ttl_r;
          r.data_len = dleft;
          if (dleft == 0) close_record();
          else ph = PH_DATA;
        end
      end
      PH_DATA: begin
        has          = 1'b1;
        r.kind       = KIND_DATA;
        r.byte_value = b;
        dleft        = dleft - 16'd1;
        if (dleft == 0) close_record();
      end
      default: trail = 1'b1;
    endcase
    if (fin) begin
      if (!has) begin
        has    = 1'b1;
        r.kind = KIND_END;
      end
      if (trail) r.verdict = VERD_TRAIL;
      else if (ph == PH_DONE) r.verdict = VERD_OK;
      else r.verdict = VERD_TRUNC;
      clear_parse();
    end
  endfunction

  function automatic void cmp(string fname, logic [31:0] e, logic [31:0] a);
    if (a !== e) begin
      n_fail++;
      if (n_fail <= 10)
        $display("%0t: result %0d, %s expected 0x%0h got 0x%0h",
                 $realtime, n_checked, fname, e, a);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      due_results.delete();
    end else begin
      if (byte_valid && !byte_stall) begin
        parse_byte(byte_in, last_byte, produced, want);
        if (produced) due_results.push_back(want);
      end
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: unexpected result beat, kind %0d verdict %0d",
                     $realtime, kind, verdict);
        end else begin
          want = due_results.pop_front();
          cmp("kind", want.kind, kind);
          cmp("verdict", want.verdict, verdict);
          cmp("byte_value", want.byte_value, byte_value);
          cmp("txn_id", want.txn_id, txn_id);
          cmp("question_count", want.question_count, question_count);
          cmp("answer_count", want.answer_count, answer_count);
          cmp("authority_count", want.authority_count, authority_count);
          cmp("additional_count", want.additional_count, additional_count);
          cmp("rtype", want.rtype, rtype);
          cmp("rclass", want.rclass, rclass);
          cmp("ttl", want.ttl, ttl);
          cmp("data_len", want.data_len, data_len);
          n_checked++;
        end
      end
    end
    outstanding   <= due_results.size();
    fail_count    <= n_fail;
    checked_count <= n_checked;
  end

endmodule

// ===== bench/tb_dns_message_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_message_parser
// Feeds the parser with datagrams: a few hand-built ones, then random
// well-formed messages, messages with trailing bytes, messages cut short and
// messages with random counts and lengths. The sender pauses in bursts and
// the receiver stalls in changing patterns; dmp_checker does the comparison.
// ----------------------------------------------------------------------------
module tb_dns_message_parser;

  localparam int ITEM_TARGET    = 420;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int NO_CAP         = 1 << 30;

  // datagram flavours
  localparam int MSG_OK    = 0;
  localparam int MSG_TRAIL = 1;
  localparam int MSG_CUT   = 2;
  localparam int MSG_WILD  = 3;

  // receiver stall patterns
  localparam logic [1:0] RX_FREE   = 2'd0;
  localparam logic [1:0] RX_LIGHT  = 2'd1;
  localparam logic [1:0] RX_HEAVY  = 2'd2;
  localparam logic [1:0] RX_TOGGLE = 2'd3;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        byte_valid   = 1'b0;
  logic        byte_stall;
  logic [7:0]  byte_in      = 8'd0;
  logic        last_byte    = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  kind;
  logic [1:0]  verdict;
  logic [7:0]  byte_value;
  logic [15:0] txn_id;
  logic [15:0] question_count;
  logic [15:0] answer_count;
  logic [15:0] authority_count;
  logic [15:0] additional_count;
  logic [15:0] rtype;
  logic [15:0] rclass;
  logic [31:0] ttl;
  logic [15:0] data_len;

  int fail_count;
  int outstanding;
  int checked_count;

  logic [7:0] dgram [$];
  int         cap;
  int         burst_left = 0;
  int         bytes_sent = 0;
  int         n_msg [4] = '{0, 0, 0, 0};
  logic       draining  = 1'b0;
  logic [1:0] stall_mode = RX_FREE;
  int         mode_left  = 0;
  logic       stall_next;
  int         idle_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dns_message_parser i_dut (
    .clk, .rst, .byte_valid, .byte_stall, .byte_in, .last_byte,
    .result_valid, .result_stall, .kind, .verdict, .byte_value, .txn_id,
    .question_count, .answer_count, .authority_count, .additional_count,
    .rtype, .rclass, .ttl, .data_len
  );

  dmp_checker i_checker (
    .clk, .rst, .byte_valid, .byte_stall, .byte_in, .last_byte,
    .result_valid, .result_stall, .kind, .verdict, .byte_value, .txn_id,
    .question_count, .answer_count, .authority_count, .additional_count,
    .rtype, .rclass, .ttl, .data_len,
    .fail_count, .outstanding, .checked_count
  );

  // receiver: stall pattern is redrawn at random whenever its countdown runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      mode_left  <= $urandom_range(8, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      RX_FREE:   stall_next = 1'b0;
      RX_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
      RX_HEAVY:  stall_next = ($urandom_range(0, 7) != 0);
      default:   stall_next = ~result_stall;
    endcase
    result_stall <= stall_next && !draining;
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic void put8(logic [7:0] v);
    if (dgram.size() < cap) dgram.push_back(v);
  endfunction

  function automatic void put16(logic [15:0] v);
    put8(v[15:8]);
    put8(v[7:0]);
  endfunction

  function automatic void put_name();
    int labels;
    int len;
    int pick;
    labels = $urandom_range(0, 3);
    for (int l = 0; l < labels; l++) begin
      pick = $urandom_range(0, 39);
      if (pick == 0)
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 191) : $urandom_range(64, 70);
      else if (pick == 1)
        len = 63;
      else
        len = $urandom_range(1, 8);
      put8(8'(len));
      for (int i = 0; i < len; i++) put8(8'($urandom));
    end
    // compressed tail or plain end of name
    if ($urandom_range(0, 3) == 0) begin
      put8(8'($urandom_range(192, 255)));
      put8(8'($urandom));
    end else begin
      put8(8'd0);
    end
  endfunction

  function automatic void put_record(bit question, bit wild);
    int len;
    put_name();
    put16(16'($urandom));
    put16(16'($urandom));
    if (!question) begin
      put16(16'($urandom));
      put16(16'($urandom));
      if (wild) len = $urandom_range(0, 65535);
      else if ($urandom_range(0, 15) == 0) len = $urandom_range(5, 40);
      else len = $urandom_range(0, 4);
      put16(16'(len));
      for (int i = 0; i < len && dgram.size() < cap; i++) put8(8'($urandom));
    end
  endfunction

  function automatic void build_message(bit wild);
    logic [15:0] cnt [4];
    bit          empty;
    empty = ($urandom_range(0, 9) == 0);
    for (int s = 0; s < 4; s++)
      cnt[s] = empty ? 16'd0 : (wild ? 16'($urandom) : 16'($urandom_range(0, 3)));
    dgram.delete();
    put16(16'($urandom));
    put16(16'($urandom));
    for (int s = 0; s < 4; s++) put16(cnt[s]);
    for (int s = 0; s < 4; s++)
      for (int r = 0; r < cnt[s] && dgram.size() < cap; r++)
        put_record(s == 0, wild);
  endfunction

  task automatic send_beat(logic [7:0] b, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        byte_valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    byte_valid <= 1'b1;
    byte_in    <= b;
    last_byte  <= fin;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_datagram(int n);
    for (int i = 0; i < n; i++) send_beat(dgram[i], i == n - 1);
  endtask

  initial begin
    int flavour;
    int pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one question with a root name, all-ones id and type
    dgram = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
              8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_datagram(dgram.size());
    n_msg[MSG_OK]++;
    // end mark on the very first byte
    dgram = '{8'hFF};
    send_datagram(1);
    n_msg[MSG_CUT]++;

    while (bytes_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) flavour = MSG_OK;
      else if (pick == 6) flavour = MSG_TRAIL;
      else if (pick == 7) flavour = MSG_CUT;
      else flavour = MSG_WILD;
      cap = (flavour == MSG_WILD) ? $urandom_range(1, 60) : NO_CAP;
      build_message(flavour == MSG_WILD);
      if (flavour == MSG_TRAIL)
        repeat ($urandom_range(1, 3)) dgram.push_back(8'($urandom));
      if (flavour == MSG_CUT && dgram.size() > 1)
        send_datagram($urandom_range(1, dgram.size() - 1));
      else
        send_datagram(dgram.size());
      n_msg[flavour]++;
    end

    byte_valid <= 1'b0;
    last_byte  <= 1'b0;
    draining   <= 1'b1;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Datagrams: %0d complete, %0d with trailing bytes, %0d cut short, %0d random",
             n_msg[MSG_OK], n_msg[MSG_TRAIL], n_msg[MSG_CUT], n_msg[MSG_WILD]);
    $display("%0d bytes sent, %0d result beats compared, %0d mismatches",
             bytes_sent, checked_count, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
